### sv/dddt_pkg.sv
// ---------------------------------------------------------------------------
// dddt_pkg: shared types and constants for the dusk/dawn clock drift tracker
// Field widths, register indexes, reset values and the light phase type.
// ---------------------------------------------------------------------------
`default_nettype none

package dddt_pkg;

   localparam int DEF_LIGHT_BITS = 10;
   localparam int THRESH_BITS    = 10;
   localparam int HOUR_BITS      = 5;
   localparam int MINUTE_BITS    = 6;
   localparam int MOD_BITS       = 11;   // minute of day, 0..1439
   localparam int CORR_BITS      = 11;
   localparam int DB_BITS        = 6;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 10;

   localparam int MIN_PER_DAY    = 1440;
   localparam int MIN_PER_HOUR   = 60;
   localparam int HALF_DAY       = 720;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DUSK_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DAWN_THRESHOLD   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SUMMER_MIN_HOURS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINTER_MAX_HOURS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SUMMER_MIDNIGHT  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINTER_MIDNIGHT  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEADBAND         = 3'd6;

   localparam logic [THRESH_BITS-1:0] RST_DUSK_THRESHOLD   = 10'd300;
   localparam logic [THRESH_BITS-1:0] RST_DAWN_THRESHOLD   = 10'd400;
   localparam logic [HOUR_BITS-1:0]   RST_SUMMER_MIN_HOURS = 5'd14;
   localparam logic [HOUR_BITS-1:0]   RST_WINTER_MAX_HOURS = 5'd10;
   localparam logic [HOUR_BITS-1:0]   RST_SUMMER_MIDNIGHT  = 5'd1;
   localparam logic [HOUR_BITS-1:0]   RST_WINTER_MIDNIGHT  = 5'd0;
   localparam logic [DB_BITS-1:0]     RST_DEADBAND         = 6'd2;

   typedef enum logic [1:0] {
      PHASE_UNKNOWN = 2'd0,
      PHASE_DAY     = 2'd1,
      PHASE_NIGHT   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] dusk_threshold;
      logic [THRESH_BITS-1:0] dawn_threshold;
      logic [HOUR_BITS-1:0]   summer_min_hours;
      logic [HOUR_BITS-1:0]   winter_max_hours;
      logic [HOUR_BITS-1:0]   summer_midnight_hour;
      logic [HOUR_BITS-1:0]   winter_midnight_hour;
      logic [DB_BITS-1:0]     correction_deadband;
   } cfg_type;

   // v * 60 as (v << 6) - (v << 2); 63 * 60 still fits 12 bits
   function automatic logic [11:0] times60(input logic [5:0] v);
      logic [11:0] w;
      w = 12'(v);
      return (w << 6) - (w << 2);
   endfunction

endpackage

`default_nettype wire

### sv/dusk_dawn_clock_drift_tracker.sv
// Each accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless stalled; an input register and a result
// register separate the channels, so a new item is taken while a result waits.
// Reset (synchronous): clears the light phase, dusk record and dawn history,
// sets the target hour and all registers to their defaults, empties both stages.
// ---------------------------------------------------------------------------
// dusk_dawn_clock_drift_tracker: light hysteresis and dawn drift correction
// Tracks day/night from light samples, corrects clock drift at dawn after a dusk.
// ---------------------------------------------------------------------------
`default_nettype none

module dusk_dawn_clock_drift_tracker
   import dddt_pkg::*;
#(
   parameter int LIGHT_BITS = DEF_LIGHT_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [LIGHT_BITS-1:0]    req_light_level,
   input  wire logic [HOUR_BITS-1:0]     req_hour_of_day,
   input  wire logic [MINUTE_BITS-1:0]   req_minute_of_hour,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [CORR_BITS-1:0]   rsp_drift_correction,
   output logic                          rsp_dark,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int CMP_BITS = (LIGHT_BITS > THRESH_BITS) ? LIGHT_BITS : THRESH_BITS;

   cfg_type cfg_ff;

   // input stage
   logic                  s1_valid_ff;
   logic [LIGHT_BITS-1:0] s1_light_ff;
   logic [MOD_BITS-1:0]   s1_now_ff;
   logic [MOD_BITS-1:0]   now_in;

   // tracker state
   phase_type             phase_ff, phase_in;
   logic [MOD_BITS-1:0]   dusk_minute_ff, dusk_minute_in;
   logic                  dusk_seen_ff, dusk_seen_in;
   logic                  cycle_done_ff, cycle_done_in;
   logic [HOUR_BITS-1:0]  target_hour_ff, target_hour_in;

   // result stage
   logic                  rsp_valid_ff;
   logic signed [CORR_BITS-1:0] corr_ff, corr_in;
   logic                  dark_ff, dark_in;

   logic                  advance;
   logic                  fire;
   logic                  load;
   logic                  below_dusk;
   logic                  above_dawn;
   logic [HOUR_BITS-1:0]  calc_target;
   logic signed [CORR_BITS-1:0] calc_corr;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drift_correction = corr_ff;
   assign rsp_dark             = dark_ff;

   dddt_time_conv u_time_conv (
      .hour   (req_hour_of_day),
      .minute (req_minute_of_hour),
      .now    (now_in)
   );

   dddt_dawn_calc u_dawn_calc (
      .now         (s1_now_ff),
      .dusk_minute (dusk_minute_ff),
      .target_hour (target_hour_ff),
      .cycle_done  (cycle_done_ff),
      .cfg         (cfg_ff),
      .target_next (calc_target),
      .correction  (calc_corr)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dusk_threshold       <= RST_DUSK_THRESHOLD;
         cfg_ff.dawn_threshold       <= RST_DAWN_THRESHOLD;
         cfg_ff.summer_min_hours     <= RST_SUMMER_MIN_HOURS;
         cfg_ff.winter_max_hours     <= RST_WINTER_MAX_HOURS;
         cfg_ff.summer_midnight_hour <= RST_SUMMER_MIDNIGHT;
         cfg_ff.winter_midnight_hour <= RST_WINTER_MIDNIGHT;
         cfg_ff.correction_deadband  <= RST_DEADBAND;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DUSK_THRESHOLD:   cfg_ff.dusk_threshold <= csr_data[THRESH_BITS-1:0];
            CSR_DAWN_THRESHOLD:   cfg_ff.dawn_threshold <= csr_data[THRESH_BITS-1:0];
            CSR_SUMMER_MIN_HOURS: cfg_ff.summer_min_hours <= csr_data[HOUR_BITS-1:0];
            CSR_WINTER_MAX_HOURS: cfg_ff.winter_max_hours <= csr_data[HOUR_BITS-1:0];
            CSR_SUMMER_MIDNIGHT:  cfg_ff.summer_midnight_hour <= csr_data[HOUR_BITS-1:0];
            CSR_WINTER_MIDNIGHT:  cfg_ff.winter_midnight_hour <= csr_data[HOUR_BITS-1:0];
            CSR_DEADBAND:         cfg_ff.correction_deadband <= csr_data[DB_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_light_ff <= req_light_level;
         s1_now_ff   <= now_in;
      end
   end

   // tracker state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_UNKNOWN;
         dusk_minute_ff <= '0;
         dusk_seen_ff   <= 1'b0;
         cycle_done_ff  <= 1'b0;
         target_hour_ff <= RST_WINTER_MIDNIGHT;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         dusk_minute_ff <= dusk_minute_in;
         dusk_seen_ff   <= dusk_seen_in;
         cycle_done_ff  <= cycle_done_in;
         target_hour_ff <= target_hour_in;
         rsp_valid_ff   <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         corr_ff <= corr_in;
         dark_ff <= dark_in;
      end
   end

   always_comb begin
      below_dusk     = CMP_BITS'(s1_light_ff) < CMP_BITS'(cfg_ff.dusk_threshold);
      above_dawn     = CMP_BITS'(s1_light_ff) > CMP_BITS'(cfg_ff.dawn_threshold);
      phase_in       = phase_ff;
      dusk_minute_in = dusk_minute_ff;
      dusk_seen_in   = dusk_seen_ff;
      cycle_done_in  = cycle_done_ff;
      target_hour_in = target_hour_ff;
      corr_in        = '0;
      if (s1_valid_ff) begin
         case (phase_ff)
            PHASE_DAY: begin
               if (below_dusk) begin
                  phase_in       = PHASE_NIGHT;
                  dusk_minute_in = s1_now_ff;
                  dusk_seen_in   = 1'b1;
               end
            end
            PHASE_NIGHT: begin
               if (above_dawn) begin
                  phase_in = PHASE_DAY;
                  if (dusk_seen_ff) begin
                     target_hour_in = calc_target;
                     cycle_done_in  = 1'b1;
                     corr_in        = calc_corr;
                  end
               end
            end
            default: begin
               if (below_dusk) begin
                  phase_in = PHASE_NIGHT;
               end else if (above_dawn) begin
                  phase_in = PHASE_DAY;
               end
            end
         endcase
      end
      // dark is high exactly when the next phase is night, and low while unknown
      dark_in = (phase_in == PHASE_NIGHT);
   end

endmodule

`default_nettype wire

### sv/dddt_time_conv.sv
// ---------------------------------------------------------------------------
// dddt_time_conv: clock hour and minute to minute of day
// Out-of-range times wrap by one day at most.
// ---------------------------------------------------------------------------
`default_nettype none

module dddt_time_conv
   import dddt_pkg::*;
(
   input  wire logic [HOUR_BITS-1:0]   hour,
   input  wire logic [MINUTE_BITS-1:0] minute,
   output logic      [MOD_BITS-1:0]    now
);

   logic [11:0] raw;

   always_comb begin
      raw = times60(6'(hour)) + 12'(minute);
      if (raw >= 12'(MIN_PER_DAY)) begin
         raw = raw - 12'(MIN_PER_DAY);
      end
      now = raw[MOD_BITS-1:0];
   end

endmodule

`default_nettype wire

### sv/dddt_dawn_calc.sv
// ---------------------------------------------------------------------------
// dddt_dawn_calc: night length, season target and midnight error at dawn
// Pure combinational; the caller decides when its results are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module dddt_dawn_calc
   import dddt_pkg::*;
(
   input  wire logic [MOD_BITS-1:0]  now,
   input  wire logic [MOD_BITS-1:0]  dusk_minute,
   input  wire logic [HOUR_BITS-1:0] target_hour,
   input  wire logic                 cycle_done,
   input  wire cfg_type              cfg,
   output logic      [HOUR_BITS-1:0] target_next,
   output logic signed [CORR_BITS-1:0] correction
);

   logic [11:0]        night_wide;
   logic [MOD_BITS-1:0] night;
   logic [11:0]        day_len;
   logic [11:0]        summer_lim;
   logic [11:0]        winter_lim;
   logic [11:0]        mid_sum;
   logic [11:0]        target_min;
   logic signed [11:0] diff;
   logic signed [11:0] err;
   logic signed [11:0] db;
   logic signed [11:0] neg;

   always_comb begin
      if (now >= dusk_minute) begin
         night_wide = 12'(now) - 12'(dusk_minute);
      end else begin
         night_wide = 12'(now) + 12'(MIN_PER_DAY) - 12'(dusk_minute);
      end
      night   = night_wide[MOD_BITS-1:0];
      day_len = 12'(MIN_PER_DAY) - 12'(night);

      // hours > S  <=>  minutes >= (S+1)*60 ; hours < W  <=>  minutes < W*60
      summer_lim = times60(6'(cfg.summer_min_hours) + 6'd1);
      winter_lim = times60(6'(cfg.winter_max_hours));
      if (day_len >= summer_lim) begin
         target_next = cfg.summer_midnight_hour;
      end else if (day_len < winter_lim) begin
         target_next = cfg.winter_midnight_hour;
      end else begin
         target_next = target_hour;
      end

      mid_sum = 12'(dusk_minute) + 12'(night[MOD_BITS-1:1]);
      if (mid_sum >= 12'(MIN_PER_DAY)) begin
         mid_sum = mid_sum - 12'(MIN_PER_DAY);
      end

      target_min = times60(6'(target_next));
      diff = $signed(mid_sum) - $signed(target_min);
      if (diff > 12'sd720) begin
         err = diff - 12'sd1440;
      end else if (diff < -12'sd720) begin
         err = diff + 12'sd1440;
      end else begin
         err = diff;
      end

      db  = $signed(12'(cfg.correction_deadband));
      neg = -err;
      if (!cycle_done || err > db || err < -db) begin
         correction = neg[CORR_BITS-1:0];
      end else begin
         correction = '0;
      end
   end

endmodule

`default_nettype wire

### sv/dddt_checker.sv
// ---------------------------------------------------------------------------
// dddt_checker: port-level checks for the dusk/dawn clock drift tracker
// Watches reset, backpressure and result plausibility; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dddt_checker
   import dddt_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic signed [CORR_BITS-1:0] rsp_drift_correction,
   input wire logic                   rsp_dark
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input side only stalls when a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // a correction only comes at dawn, which ends the night
   a_corr_day: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drift_correction != '0) |-> !rsp_dark)
      else $error("nonzero correction while dark");

   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drift_correction >= -HALF_DAY &&
                     rsp_drift_correction <= HALF_DAY))
      else $error("correction beyond half a day");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drift_correction)
                                    && $stable(rsp_dark)))
      else $error("stalled item changed");

endmodule

bind dusk_dawn_clock_drift_tracker dddt_checker u_dddt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_drift_correction (rsp_drift_correction),
   .rsp_dark             (rsp_dark)
);

`default_nettype wire

### verif/tb_dusk_dawn_clock_drift_tracker.sv
// ---------------------------------------------------------------------------
// tb_dusk_dawn_clock_drift_tracker: self-checking bench for the drift tracker
// Streams light/time samples with random bursts, gaps and output stalls.
// A behavioral day/night tracker predicts each correction and dark flag.
// Settings change between phases, including crossed, stuck and out-of-range values.
// ---------------------------------------------------------------------------
module tb_dusk_dawn_clock_drift_tracker;
   import dddt_pkg::*;

   localparam int LB              = DEF_LIGHT_BITS;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int NUM_PHASES      = 9;
   localparam int NUM_OPENING     = 21;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic signed [CORR_BITS-1:0] corr;
      logic                        dark;
   } fix_type;

   typedef struct {
      logic [LB-1:0]               light;
      logic [HOUR_BITS-1:0]        hour;
      logic [MINUTE_BITS-1:0]      minute;
      bit                          typed;
      logic signed [CORR_BITS-1:0] corr;
      logic                        dark;
   } sample_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [LB-1:0]                 req_light_level = '0;
   logic [HOUR_BITS-1:0]          req_hour_of_day = '0;
   logic [MINUTE_BITS-1:0]        req_minute_of_hour = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [CORR_BITS-1:0]   rsp_drift_correction;
   logic                          rsp_dark;
   logic                          csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   dusk_dawn_clock_drift_tracker #(.LIGHT_BITS(LB)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_light_level      (req_light_level),
      .req_hour_of_day      (req_hour_of_day),
      .req_minute_of_hour   (req_minute_of_hour),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drift_correction (rsp_drift_correction),
      .rsp_dark             (rsp_dark),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tracker state mirrored by the bench
   cfg_type              settings;
   phase_type            track_phase;
   logic                 track_dark;
   logic [MOD_BITS-1:0]  dusk_at;
   logic                 dusk_logged;
   logic                 first_dawn_done;
   logic [HOUR_BITS-1:0] target_hour;

   fix_type owed_fixes[$];
   int   mismatches   = 0;
   int   results_seen = 0;
   int   quiet_cycles = 0;

   // sample generator and sender pacing
   int burst_left = 0;
   int clock_min  = 0;
   bit aim_night  = 1'b0;
   int aim_left   = 0;

   sample_row_type opening_rows [0:NUM_OPENING-1] = '{
      '{10'd350,  5'd0,  6'd0,  1'b1, 11'sd0,   1'b0},  // in band while unknown
      '{10'd0,    5'd1,  6'd0,  1'b1, 11'sd0,   1'b1},  // unknown straight to night
      '{10'd1023, 5'd5,  6'd30, 1'b1, 11'sd0,   1'b0},  // dawn without a dusk
      '{10'd512,  5'd12, 6'd0,  1'b1, 11'sd0,   1'b0},
      '{10'd300,  5'd18, 6'd0,  1'b1, 11'sd0,   1'b0},  // equal to dusk level
      '{10'd0,    5'd20, 6'd0,  1'b1, 11'sd0,   1'b1},  // dusk at 20:00
      '{10'd400,  5'd23, 6'd0,  1'b1, 11'sd0,   1'b1},  // equal to dawn level
      '{10'd1023, 5'd6,  6'd0,  1'b1, -11'sd60, 1'b0},  // first dawn, full correction
      '{10'd0,    5'd20, 6'd2,  1'b0, 11'sd0,   1'b0},
      '{10'd1023, 5'd6,  6'd0,  1'b0, 11'sd0,   1'b0},
      '{10'd0,    5'd20, 6'd0,  1'b0, 11'sd0,   1'b0},
      '{10'd1023, 5'd4,  6'd0,  1'b0, 11'sd0,   1'b0},  // long day, summer target
      '{10'd0,    5'd31, 6'd63, 1'b0, 11'sd0,   1'b0},  // time past midnight wraps
      '{10'd1023, 5'd24, 6'd0,  1'b0, 11'sd0,   1'b0},
      '{10'd0,    5'd23, 6'd59, 1'b0, 11'sd0,   1'b0},
      '{10'd1023, 5'd0,  6'd1,  1'b0, 11'sd0,   1'b0},
      '{10'd0,    5'd0,  6'd0,  1'b0, 11'sd0,   1'b0},
      '{10'd1023, 5'd0,  6'd0,  1'b0, 11'sd0,   1'b0},  // zero-length night
      '{10'd1000, 5'd12, 6'd34, 1'b0, 11'sd0,   1'b0},
      '{10'd5,    5'd19, 6'd45, 1'b0, 11'sd0,   1'b0},
      '{10'd700,  5'd22, 6'd17, 1'b0, 11'sd0,   1'b0}
   };

   function automatic void clear_tracker();
      settings = '{dusk_threshold:       RST_DUSK_THRESHOLD,
                   dawn_threshold:       RST_DAWN_THRESHOLD,
                   summer_min_hours:     RST_SUMMER_MIN_HOURS,
                   winter_max_hours:     RST_WINTER_MAX_HOURS,
                   summer_midnight_hour: RST_SUMMER_MIDNIGHT,
                   winter_midnight_hour: RST_WINTER_MIDNIGHT,
                   correction_deadband:  RST_DEADBAND};
      track_phase     = PHASE_UNKNOWN;
      track_dark      = 1'b0;
      dusk_at         = '0;
      dusk_logged     = 1'b0;
      first_dawn_done = 1'b0;
      target_hour     = RST_WINTER_MIDNIGHT;
   endfunction

   function automatic fix_type advance_tracker(input logic [LB-1:0] light,
                                               input logic [HOUR_BITS-1:0] hr,
                                               input logic [MINUTE_BITS-1:0] mn);
      int   now, night, hours, midpoint, diff, err, corr, band;
      fix_type res;
      corr = 0;
      now  = int'(hr) * MIN_PER_HOUR + int'(mn);
      if (now >= MIN_PER_DAY) now -= MIN_PER_DAY;
      case (track_phase)
         PHASE_DAY: begin
            track_dark = 1'b0;
            if (light < settings.dusk_threshold) begin
               track_phase = PHASE_NIGHT;
               track_dark  = 1'b1;
               dusk_at     = MOD_BITS'(now);
               dusk_logged = 1'b1;
            end
         end
         PHASE_NIGHT: begin
            track_dark = 1'b1;
            if (light > settings.dawn_threshold) begin
               track_phase = PHASE_DAY;
               track_dark  = 1'b0;
               if (dusk_logged) begin
                  if (now >= int'(dusk_at)) night = now - int'(dusk_at);
                  else night = MIN_PER_DAY - int'(dusk_at) + now;
                  // summer test wins over winter; in between the target holds
                  hours = (MIN_PER_DAY - night) / MIN_PER_HOUR;
                  if (hours > int'(settings.summer_min_hours))
                     target_hour = settings.summer_midnight_hour;
                  else if (hours < int'(settings.winter_max_hours))
                     target_hour = settings.winter_midnight_hour;
                  midpoint = int'(dusk_at) + night / 2;
                  if (midpoint >= MIN_PER_DAY) midpoint -= MIN_PER_DAY;
                  diff = midpoint - int'(target_hour) * MIN_PER_HOUR;
                  err  = diff;
                  if (diff > HALF_DAY) err = diff - MIN_PER_DAY;
                  else if (diff < -HALF_DAY) err = diff + MIN_PER_DAY;
                  band = int'(settings.correction_deadband);
                  if (!first_dawn_done || err > band || err < -band) corr = -err;
                  first_dawn_done = 1'b1;
               end
            end
         end
         default: begin
            if (light < settings.dusk_threshold) begin
               track_phase = PHASE_NIGHT;
               track_dark  = 1'b1;
            end else if (light > settings.dawn_threshold) begin
               track_phase = PHASE_DAY;
               track_dark  = 1'b0;
            end
         end
      endcase
      res.corr = CORR_BITS'(corr);
      res.dark = track_dark;
      return res;
   endfunction

   function automatic cfg_type phase_settings(input int ph);
      cfg_type c;
      c.dusk_threshold       = THRESH_BITS'($urandom_range(700, 50));
      c.dawn_threshold       = THRESH_BITS'(int'(c.dusk_threshold) + $urandom_range(300, 0));
      c.summer_min_hours     = HOUR_BITS'($urandom_range(18, 10));
      c.winter_max_hours     = HOUR_BITS'($urandom_range(12, 6));
      c.summer_midnight_hour = HOUR_BITS'($urandom_range(23, 0));
      c.winter_midnight_hour = HOUR_BITS'($urandom_range(23, 0));
      c.correction_deadband  = DB_BITS'($urandom_range(60, 0));
      case (ph)
         1: begin  // crossed thresholds, nearly every sample flips the phase
            c.dusk_threshold       = 10'd1023;
            c.dawn_threshold       = 10'd0;
            c.summer_min_hours     = 5'd0;
            c.winter_max_hours     = 5'd24;
            c.summer_midnight_hour = 5'd23;
            c.winter_midnight_hour = 5'd0;
            c.correction_deadband  = 6'd60;
         end
         3: begin  // no transition possible, dusk at zero, the rest at their top
            c.dusk_threshold       = 10'd0;
            c.dawn_threshold       = 10'd1023;
            c.summer_min_hours     = 5'd31;
            c.winter_max_hours     = 5'd31;
            c.summer_midnight_hour = 5'd31;
            c.winter_midnight_hour = 5'd31;
            c.correction_deadband  = 6'd63;
         end
         4: begin  // never summer, always winter, target hour past the day
            c.summer_min_hours     = 5'd31;
            c.winter_max_hours     = 5'd25;
            c.summer_midnight_hour = 5'd30;
            c.winter_midnight_hour = 5'd31;
            c.correction_deadband  = 6'd63;
         end
         5: begin  // neither season test can fire
            c.summer_min_hours     = 5'd24;
            c.winter_max_hours     = 5'd0;
            c.correction_deadband  = 6'd0;
         end
         8: begin
            c.dusk_threshold = 10'd1;
            c.dawn_threshold = 10'd1022;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic csr_put(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      case (idx)
         CSR_DUSK_THRESHOLD:   settings.dusk_threshold       = d[THRESH_BITS-1:0];
         CSR_DAWN_THRESHOLD:   settings.dawn_threshold       = d[THRESH_BITS-1:0];
         CSR_SUMMER_MIN_HOURS: settings.summer_min_hours     = d[HOUR_BITS-1:0];
         CSR_WINTER_MAX_HOURS: settings.winter_max_hours     = d[HOUR_BITS-1:0];
         CSR_SUMMER_MIDNIGHT:  settings.summer_midnight_hour = d[HOUR_BITS-1:0];
         CSR_WINTER_MIDNIGHT:  settings.winter_midnight_hour = d[HOUR_BITS-1:0];
         CSR_DEADBAND:         settings.correction_deadband  = d[DB_BITS-1:0];
         default: ;
      endcase
   endtask

   // upper data bits above a register's width are random and must be dropped
   task automatic load_settings(input cfg_type c);
      csr_put(CSR_SPARE, CSR_DATA_BITS'($urandom));
      csr_put(CSR_DUSK_THRESHOLD, c.dusk_threshold);
      csr_put(CSR_DAWN_THRESHOLD, c.dawn_threshold);
      csr_put(CSR_SUMMER_MIN_HOURS, {5'($urandom), c.summer_min_hours});
      csr_put(CSR_WINTER_MAX_HOURS, {5'($urandom), c.winter_max_hours});
      csr_put(CSR_SUMMER_MIDNIGHT, {5'($urandom), c.summer_midnight_hour});
      csr_put(CSR_WINTER_MIDNIGHT, {5'($urandom), c.winter_midnight_hour});
      csr_put(CSR_DEADBAND, {4'($urandom), c.correction_deadband});
      csr_write <= 1'b0;
   endtask

   task automatic offer(input logic [LB-1:0] l, input logic [HOUR_BITS-1:0] h,
                        input logic [MINUTE_BITS-1:0] m, output fix_type predicted);
      req_valid          <= 1'b1;
      req_light_level    <= l;
      req_hour_of_day    <= h;
      req_minute_of_hour <= m;
      do @(posedge clock); while (req_stall);
      predicted = advance_tracker(l, h, m);
   endtask

   task automatic sender_pause();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(30, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [LB-1:0] bright_light();
      if (settings.dawn_threshold == '1) return '1;
      return LB'($urandom_range(1023, int'(settings.dawn_threshold) + 1));
   endfunction

   function automatic logic [LB-1:0] dim_light();
      if (settings.dusk_threshold == '0) return '0;
      return LB'($urandom_range(int'(settings.dusk_threshold) - 1, 0));
   endfunction

   // mostly clean day/night cycles on a moving clock, some band and noise samples
   task automatic make_sample(output logic [LB-1:0] l, output logic [HOUR_BITS-1:0] h,
                              output logic [MINUTE_BITS-1:0] m);
      int pick;
      pick      = $urandom_range(99, 0);
      clock_min = (clock_min + $urandom_range(90, 1)) % MIN_PER_DAY;
      h         = HOUR_BITS'(clock_min / MIN_PER_HOUR);
      m         = MINUTE_BITS'(clock_min % MIN_PER_HOUR);
      if (pick < 80) begin
         if (aim_left == 0) begin
            aim_night = !aim_night;
            aim_left  = $urandom_range(8, 2);
         end
         aim_left--;
         l = aim_night ? dim_light() : bright_light();
      end else if (pick < 90 && settings.dawn_threshold >= settings.dusk_threshold) begin
         l = LB'($urandom_range(int'(settings.dawn_threshold),
                                int'(settings.dusk_threshold)));
      end else begin
         l = LB'($urandom);
         h = HOUR_BITS'($urandom);
         m = MINUTE_BITS'($urandom);
      end
   endtask

   task automatic drain();
      while (owed_fixes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      fix_type                p;
      fix_type                typed_fix;
      logic [LB-1:0]          l;
      logic [HOUR_BITS-1:0]   h;
      logic [MINUTE_BITS-1:0] m;
      int                     k, ph, count;
      clear_tracker();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < NUM_OPENING; k++) begin
         if (k > 0) sender_pause();
         offer(opening_rows[k].light, opening_rows[k].hour, opening_rows[k].minute, p);
         if (opening_rows[k].typed) begin
            typed_fix.corr = opening_rows[k].corr;
            typed_fix.dark = opening_rows[k].dark;
            owed_fixes.push_back(typed_fix);
         end else begin
            owed_fixes.push_back(p);
         end
      end
      req_valid <= 1'b0;

      // phase 0 keeps the reset settings
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         if (ph > 0) load_settings(phase_settings(ph));
         count = (ph == 3) ? 40 : 210;
         for (k = 0; k < count; k++) begin
            if (k > 0) sender_pause();
            make_sample(l, h, m);
            offer(l, h, m, p);
            owed_fixes.push_back(p);
         end
         req_valid <= 1'b0;
      end

      drain();
      if (mismatches == 0 && owed_fixes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   always @(posedge clock) begin : check_results
      fix_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (owed_fixes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d with none pending: corr %0d dark %0b",
                        results_seen, rsp_drift_correction, rsp_dark);
         end else begin
            want = owed_fixes.pop_front();
            if (rsp_drift_correction !== want.corr || rsp_dark !== want.dark) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: corr exp %0d got %0d, dark exp %0b got %0b",
                           results_seen, want.corr, rsp_drift_correction,
                           want.dark, rsp_dark);
            end
         end
      end
   end

   // output back-pressure; one long hold-off lets the block fill and stall its input
   initial begin
      stall_mode_type mode;
      int          left, period;
      bit          held;
      mode   = STALL_NONE;
      left   = 0;
      period = 3;
      held   = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= 600) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (left == 0) begin
            mode   = stall_mode_type'($urandom_range(3, 0));
            left   = $urandom_range(150, 20);
            period = $urandom_range(5, 2);
         end
         left--;
         case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(99, 0) < 30);
            STALL_HEAVY: rsp_stall <= ($urandom_range(99, 0) < 75);
            default:     rsp_stall <= ((left % period) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
